// ===== rtl/fixed_block_pool_allocator_macros.svh =====
// Assertion macros used by the pool allocator RTL.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define FBPA_ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FBPA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/fbpa_pkg.sv =====
// Shared types and constants of the block pool allocator.
package fbpa_pkg;

  // Request and result field widths
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd3;

  // Block count after reset
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 7'd64;

  // Counter unit operation
  typedef enum logic {
    ALU_INC = 1'b0,
    ALU_DEC = 1'b1
  } alu_op_t;

endpackage

// ===== rtl/fbpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fbpa_alu.sv =====
// Shared counter unit: increment or decrement plus a below-limit compare.
module fbpa_alu #(
  parameter int W = 7
) (
  input  logic             [W-1:0] a,
  input  logic             [W-1:0] limit,
  input  fbpa_pkg::alu_op_t        op,
  output logic             [W-1:0] sum,
  output logic                     lt
);

  // One adder serves both directions
  assign sum = (op == fbpa_pkg::ALU_DEC) ? a - W'(1) : a + W'(1);
  assign lt  = (a < limit);

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: free stack in RAM, used marks in flops, small sequencer.
//
// Manages MAX_BLOCKS equal blocks by index. One request is taken at a time; s_tready
// is high only while the sequencer is idle, and a finished result may still sit in
// the output register while the next request is taken. Allocate and free pass through
// one further state after the request, for the free-stack RAM read or write. Init
// writes one stack entry per cycle up to the saturated count. Scan tests one used
// mark per cycle while no found block waits on a full output register. The single
// counter unit and single RAM write port set this pace; output back-pressure adds its
// own stalls. block_count takes effect at the next init and saturates at MAX_BLOCKS.
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Config register block_count
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // Requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [5:0] block_index, [7:6] zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] result_index, [12:6] free_count, [15:13] zero
  output logic        m_tuser,   // [0] ok
  output logic        m_tlast    // last result of the request
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_ALLOC = 3'd2;
  localparam logic [2:0] ST_FREE  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_REPLY = 3'd5;

  logic [2:0]                     state, state_next;
  logic [fbpa_pkg::COUNT_W-1:0]   block_count;
  logic [CW-1:0]                  free_top, free_top_next;
  logic [CW-1:0]                  pool_count, pool_count_next;
  logic                           started, started_next;
  logic [CW-1:0]                  ptr, ptr_next;
  logic [fbpa_pkg::INDEX_W-1:0]   bi, bi_next;
  logic                           have_pend, have_pend_next;
  logic [IW-1:0]                  pend_idx, pend_idx_next;
  logic [MAX_BLOCKS-1:0]          used_mark;

  logic                           used_set, used_clr, used_clear_all;
  logic [IW-1:0]                  used_sel;

  logic                           ram_we;
  logic [IW-1:0]                  ram_waddr, ram_wdata, ram_rdata;

  logic [CW-1:0]                  alu_a, alu_limit, alu_sum;
  fbpa_pkg::alu_op_t              alu_op;
  logic                           alu_lt;

  logic                           out_free, emit, emit_ok, emit_last;
  logic [IW-1:0]                  emit_idx;
  logic [CW-1:0]                  emit_count;

  logic                           accept;
  logic [fbpa_pkg::INDEX_W-1:0]   in_bi;
  logic [CW-1:0]                  cnt_sat;
  logic                           free_ok;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_bi    = s_tdata[fbpa_pkg::INDEX_W-1:0];
  assign out_free = !m_tvalid || m_tready;

  // Saturated block count for init
  assign cnt_sat = (block_count > fbpa_pkg::COUNT_W'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                                : block_count[CW-1:0];

  // Free request check: started, in range, marked used, stack not full
  assign free_ok = started
                && (fbpa_pkg::COUNT_W'(in_bi) < fbpa_pkg::COUNT_W'(pool_count))
                && used_mark[in_bi[IW-1:0]]
                && (free_top != CW'(MAX_BLOCKS));

  // Free stack storage
  fbpa_ram #(
    .WIDTH(IW),
    .DEPTH(MAX_BLOCKS)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(alu_sum[IW-1:0]),
    .rdata(ram_rdata)
  );

  // Shared counter unit
  fbpa_alu #(
    .W(CW)
  ) u_alu (
    .a    (alu_a),
    .limit(alu_limit),
    .op   (alu_op),
    .sum  (alu_sum),
    .lt   (alu_lt)
  );

  // Sequencer
  always_comb begin
    state_next      = state;
    free_top_next   = free_top;
    pool_count_next = pool_count;
    started_next    = started;
    ptr_next        = ptr;
    bi_next         = bi;
    have_pend_next  = have_pend;
    pend_idx_next   = pend_idx;
    used_set        = 1'b0;
    used_clr        = 1'b0;
    used_clear_all  = 1'b0;
    used_sel        = bi[IW-1:0];
    ram_we          = 1'b0;
    ram_waddr       = free_top[IW-1:0];
    ram_wdata       = bi[IW-1:0];
    alu_a           = free_top;
    alu_op          = fbpa_pkg::ALU_DEC;
    alu_limit       = pool_count;
    emit            = 1'b0;
    emit_ok         = 1'b0;
    emit_idx        = '0;
    emit_count      = free_top;
    emit_last       = 1'b1;

    unique case (state)
      ST_IDLE: begin
        // Counter unit computes free_top - 1 as the pop read address
        if (accept) begin
          bi_next = in_bi;
          unique case (s_tuser)
            fbpa_pkg::KIND_INIT: begin
              pool_count_next = cnt_sat;
              free_top_next   = cnt_sat;
              started_next    = 1'b1;
              used_clear_all  = 1'b1;
              ptr_next        = '0;
              state_next      = ST_INIT;
            end
            fbpa_pkg::KIND_ALLOC: begin
              state_next = (started && (free_top != '0)) ? ST_ALLOC : ST_REPLY;
            end
            fbpa_pkg::KIND_FREE: begin
              state_next = free_ok ? ST_FREE : ST_REPLY;
            end
            fbpa_pkg::KIND_SCAN: begin
              ptr_next       = '0;
              have_pend_next = 1'b0;
              state_next     = ST_SCAN;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_INIT: begin
        // Write stack[ptr] = ptr, one entry per cycle
        alu_a  = ptr;
        alu_op = fbpa_pkg::ALU_INC;
        if (alu_lt) begin
          ram_we    = 1'b1;
          ram_waddr = ptr[IW-1:0];
          ram_wdata = ptr[IW-1:0];
          ptr_next  = alu_sum;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_ok    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        // Read data holds the popped block
        if (out_free) begin
          emit          = 1'b1;
          emit_ok       = 1'b1;
          emit_idx      = ram_rdata;
          emit_count    = alu_sum;
          free_top_next = alu_sum;
          used_set      = 1'b1;
          used_sel      = ram_rdata;
          state_next    = ST_IDLE;
        end
      end
      ST_FREE: begin
        // Push the block and clear its mark
        alu_op = fbpa_pkg::ALU_INC;
        if (out_free) begin
          ram_we        = 1'b1;
          used_clr      = 1'b1;
          free_top_next = alu_sum;
          emit          = 1'b1;
          emit_ok       = 1'b1;
          emit_count    = alu_sum;
          state_next    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // One mark per cycle save output stalls; found block held till next sets last
        alu_a     = ptr;
        alu_op    = fbpa_pkg::ALU_INC;
        alu_limit = CW'(MAX_BLOCKS);
        if (alu_lt) begin
          if (used_mark[ptr[IW-1:0]]) begin
            if (!have_pend) begin
              have_pend_next = 1'b1;
              pend_idx_next  = ptr[IW-1:0];
              ptr_next       = alu_sum;
            end else if (out_free) begin
              emit          = 1'b1;
              emit_ok       = 1'b1;
              emit_idx      = pend_idx;
              emit_last     = 1'b0;
              pend_idx_next = ptr[IW-1:0];
              ptr_next      = alu_sum;
            end
          end else begin
            ptr_next = alu_sum;
          end
        end else if (out_free) begin
          emit       = 1'b1;
          emit_ok    = have_pend;
          emit_idx   = have_pend ? pend_idx : '0;
          state_next = ST_IDLE;
        end
      end
      ST_REPLY: begin
        // Failed allocate or free request
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      block_count <= fbpa_pkg::BLOCK_COUNT_RST;
      free_top    <= '0;
      pool_count  <= '0;
      started     <= 1'b0;
      have_pend   <= 1'b0;
      used_mark   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state      <= state_next;
      free_top   <= free_top_next;
      pool_count <= pool_count_next;
      started    <= started_next;
      have_pend  <= have_pend_next;
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
      if (used_clear_all) begin
        used_mark <= '0;
      end else if (used_set) begin
        used_mark[used_sel] <= 1'b1;
      end else if (used_clr) begin
        used_mark[used_sel] <= 1'b0;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    bi       <= bi_next;
    pend_idx <= pend_idx_next;
    if (emit) begin
      m_tdata <= {3'b000, fbpa_pkg::COUNT_W'(emit_count), fbpa_pkg::INDEX_W'(emit_idx)};
      m_tuser <= emit_ok;
      m_tlast <= emit_last;
    end
  end

  // Checks
  `FBPA_ASSERT_HOLDS(a_top_in_pool, clk, rst, free_top <= pool_count, "free_top above pool size")
  `FBPA_ASSERT_HOLDS(a_conserve, clk, rst, $countones(used_mark) + int'(free_top) == int'(pool_count), "used plus free differs from pool size")
  `FBPA_ASSERT_IMPLIES(a_no_overwrite, clk, rst, emit, !m_tvalid || m_tready, "result overwritten before taken")
  `FBPA_ASSERT_IMPLIES(a_pop_unused, clk, rst, state == ST_ALLOC, !used_mark[ram_rdata], "popped block already marked used")

endmodule
